### rtl/sbs_pkg.sv
// shared constants and command codes for the sorted table search block
package sbs_pkg;

  localparam int IDX_W           = 10;
  localparam int DATA_W          = 32;
  localparam int TABLE_DEPTH_DEF = 1024;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

endpackage

### rtl/sbs_table.sv
// table memory: one write port, one read port with registered read data
module sbs_table #(
  parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [sbs_pkg::DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [sbs_pkg::DATA_W-1:0] rdata
);

  logic [sbs_pkg::DATA_W-1:0] table_mem [TABLE_DEPTH];
  logic [sbs_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= table_mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/sbs_ctrl.sv
// request intake, probe sequencer and result register of the search block
module sbs_ctrl #(
  parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic [sbs_pkg::IDX_W-1:0]   in_entry_index,
  input  logic [sbs_pkg::DATA_W-1:0]  in_entry_value,
  input  logic [sbs_pkg::IDX_W-1:0]   in_low_index,
  input  logic [sbs_pkg::IDX_W-1:0]   in_high_index,
  input  logic [sbs_pkg::DATA_W-1:0]  in_search_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [sbs_pkg::IDX_W-1:0]   out_position,
  output logic                        mem_we,
  output logic [ADDR_W-1:0]           mem_waddr,
  output logic [sbs_pkg::DATA_W-1:0]  mem_wdata,
  output logic [ADDR_W-1:0]           mem_raddr,
  input  logic [sbs_pkg::DATA_W-1:0]  mem_rdata
);

  localparam int IW = sbs_pkg::IDX_W;
  localparam int CW = ((ADDR_W > IW) ? ADDR_W : IW) + 2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [CW-1:0]              lo_r, lo_nxt;
  logic signed [CW-1:0]              hi_r, hi_nxt;
  logic signed [CW-1:0]              mid_r, mid_nxt;
  logic signed [sbs_pkg::DATA_W-1:0] key_r, key_nxt;
  logic                              res_found_r, res_found_nxt;
  logic [IW-1:0]                     res_pos_r, res_pos_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_found_r, out_found_nxt;
  logic [IW-1:0]                     out_position_r, out_position_nxt;

  logic                              accept;
  logic [CW-1:0]                     widx_ext;
  logic signed [CW-1:0]              lo_in;
  logic signed [CW-1:0]              hi_in;
  logic signed [CW-1:0]              span;
  logic signed [CW-1:0]              mid_calc;
  logic signed [sbs_pkg::DATA_W-1:0] probe;
  logic                              out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign widx_ext  = {{(CW-IW){1'b0}}, in_entry_index};
  assign mem_we    = accept && (in_command == sbs_pkg::CMD_WRITE)
                     && (widx_ext < CW'(TABLE_DEPTH));
  assign mem_waddr = widx_ext[ADDR_W-1:0];
  assign mem_wdata = in_entry_value;

  assign lo_in = signed'({{(CW-IW){1'b0}}, in_low_index});
  assign hi_in = (signed'({{(CW-IW){1'b0}}, in_high_index}) > signed'(CW'(TABLE_DEPTH - 1)))
                 ? signed'(CW'(TABLE_DEPTH - 1))
                 : signed'({{(CW-IW){1'b0}}, in_high_index});

  assign span      = hi_r - lo_r;
  assign mid_calc  = lo_r + (span >>> 1);
  assign mem_raddr = mid_calc[ADDR_W-1:0];
  assign probe     = signed'(mem_rdata);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt        = state_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    mid_nxt          = mid_r;
    key_nxt          = key_r;
    res_found_nxt    = res_found_r;
    res_pos_nxt      = res_pos_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_found_nxt    = out_found_r;
    out_position_nxt = out_position_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_command == sbs_pkg::CMD_SEARCH)) begin
          lo_nxt    = lo_in;
          hi_nxt    = hi_in;
          key_nxt   = signed'(in_search_key);
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (lo_r > hi_r) begin
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          state_nxt     = ST_DONE;
        end else begin
          mid_nxt   = mid_calc;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (key_r < probe) begin
          hi_nxt    = mid_r - CW'(1);
          state_nxt = ST_PROBE;
        end else if (key_r > probe) begin
          lo_nxt    = mid_r + CW'(1);
          state_nxt = ST_PROBE;
        end else begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = mid_r[IW-1:0];
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_found_nxt    = res_found_r;
          out_position_nxt = res_pos_r;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r           <= lo_nxt;
    hi_r           <= hi_nxt;
    mid_r          <= mid_nxt;
    key_r          <= key_nxt;
    res_found_r    <= res_found_nxt;
    res_pos_r      <= res_pos_nxt;
    out_found_r    <= out_found_nxt;
    out_position_r <= out_position_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

  a_cmp_follows_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> ($past(state_r) == ST_PROBE))
    else $error("compare without a preceding probe read");

  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> ((mid_r >= lo_r) && (mid_r <= hi_r)))
    else $error("probe slot outside the search range");

  a_hi_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (hi_r <= signed'(CW'(TABLE_DEPTH - 1))))
    else $error("search range beyond the table");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_position_r == '0))
    else $error("miss result with nonzero position");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_IDLE))
    else $error("table write during a search");

endmodule

### rtl/sorted_table_binary_search_core.sv
// Sorted table binary search: a 32-bit signed table written one slot per request, searched
// over an inclusive slot range; a write request gives no result, a search holds in_ready
// low while it steps through a probe state and a compare state for every probe, as the
// table memory read is synchronous, then a done state until the output register is free;
// the result sits in an output register so the next request is taken while it waits;
// slots must be written before they are searched, there is no clearing pass after reset
module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic [sbs_pkg::IDX_W-1:0]   in_entry_index,
  input  logic [sbs_pkg::DATA_W-1:0]  in_entry_value,
  input  logic [sbs_pkg::IDX_W-1:0]   in_low_index,
  input  logic [sbs_pkg::IDX_W-1:0]   in_high_index,
  input  logic [sbs_pkg::DATA_W-1:0]  in_search_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [sbs_pkg::IDX_W-1:0]   out_position
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [sbs_pkg::DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]          mem_raddr;
  logic [sbs_pkg::DATA_W-1:0] mem_rdata;

  sbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_low_index   (in_low_index),
    .in_high_index  (in_high_index),
    .in_search_key  (in_search_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_position   (out_position),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  sbs_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

### test/sorted_table_binary_search_core_tb.sv
// testbench for the sorted table binary search core: table writes and range searches checked
`timescale 1ns / 100ps

module sorted_table_binary_search_core_tb;

  localparam int IW          = sbs_pkg::IDX_W;
  localparam int DW          = sbs_pkg::DATA_W;
  localparam int DEPTH       = sbs_pkg::TABLE_DEPTH_DEF;
  localparam int ITEM_TARGET = 1900;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 30;
  localparam logic signed [DW-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [DW-1:0] INT_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic           found;
    logic [IW-1:0]  position;
  } search_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_command;
  logic [IW-1:0]      in_entry_index;
  logic [DW-1:0]      in_entry_value;
  logic [IW-1:0]      in_low_index;
  logic [IW-1:0]      in_high_index;
  logic [DW-1:0]      in_search_key;
  logic               out_valid;
  logic               out_ready;
  logic               out_found;
  logic [IW-1:0]      out_position;

  logic signed [DW-1:0] table_copy [DEPTH];
  bit                   slot_written [DEPTH];
  search_result_t       expected_results [$];

  bit no_idle;
  int item_count;
  int write_count;
  int search_count;
  int hit_count;
  int mismatch_count;
  int stall_cycles;
  int seg_lo;
  int seg_hi;

  sorted_table_binary_search_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_low_index   (in_low_index),
    .in_high_index  (in_high_index),
    .in_search_key  (in_search_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_position   (out_position)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // binary search over the local table copy; returns 0 if an unwritten slot would be probed
  function automatic bit walk_table(input int lo_in, input int hi_in,
                                    input logic signed [DW-1:0] key,
                                    output logic hit, output logic [IW-1:0] slot);
    int lo;
    int hi;
    int mid;
    bit done;
    bit clean;
    lo    = lo_in;
    hi    = hi_in;
    hit   = 1'b0;
    slot  = '0;
    done  = 1'b0;
    clean = 1'b1;
    if (hi > DEPTH - 1) hi = DEPTH - 1;
    while (!done && lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (!slot_written[mid]) clean = 1'b0;
      if (key < table_copy[mid]) begin
        hi = mid - 1;
      end else if (key > table_copy[mid]) begin
        lo = mid + 1;
      end else begin
        hit  = 1'b1;
        slot = mid[IW-1:0];
        done = 1'b1;
      end
    end
    return clean;
  endfunction

  function automatic logic signed [DW-1:0] pick_key(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 9);
    if (lo <= hi && r < 6) return table_copy[$urandom_range(lo, hi)];
    if (lo <= hi && r < 8) return table_copy[$urandom_range(lo, hi)] + 1;
    return $urandom;
  endfunction

  task automatic send_request(input logic cmd, input logic [IW-1:0] eidx,
                              input logic [DW-1:0] evalue, input logic [IW-1:0] lo,
                              input logic [IW-1:0] hi, input logic [DW-1:0] key);
    search_result_t res;
    while (!no_idle && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_entry_index <= eidx;
    in_entry_value <= evalue;
    in_low_index   <= lo;
    in_high_index  <= hi;
    in_search_key  <= key;
    do @(posedge clk); while (!in_ready);
    item_count++;
    if (cmd == sbs_pkg::CMD_WRITE) begin
      table_copy[eidx]   = evalue;
      slot_written[eidx] = 1'b1;
      write_count++;
    end else begin
      void'(walk_table(lo, hi, key, res.found, res.position));
      expected_results.push_back(res);
      search_count++;
      if (res.found) hit_count++;
    end
  endtask

  task automatic write_entry(input int idx, input logic [DW-1:0] value);
    send_request(sbs_pkg::CMD_WRITE, idx[IW-1:0], value, IW'($urandom), IW'($urandom),
                 $urandom);
  endtask

  task automatic search_range(input int lo, input int hi, input logic [DW-1:0] key);
    send_request(sbs_pkg::CMD_SEARCH, IW'($urandom), $urandom, lo[IW-1:0], hi[IW-1:0], key);
  endtask

  // sender holds off until every pending search result is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_directed();
    logic signed [DW-1:0] vals [10];
    vals = '{INT_MIN, -1000, -1, 0, 0, 5, 77, 1000, 32'sh4000_0000, INT_MAX};
    for (int i = 0; i < 10; i++) write_entry(i, vals[i]);
    write_entry(DEPTH - 1, INT_MAX);
    search_range(0, 9, INT_MIN);
    search_range(0, 9, INT_MAX);
    search_range(0, 9, 0);
    search_range(0, 9, 3);
    search_range(0, 9, -2);
    search_range(5, 4, 5);
    search_range(DEPTH - 1, 0, INT_MAX);
    search_range(DEPTH - 1, DEPTH - 1, INT_MAX);
    search_range(DEPTH - 1, DEPTH - 1, 0);
    search_range(0, 0, INT_MIN);
    // unsorted range
    write_entry(4, -5000);
    search_range(0, 9, 0);
  endtask

  task automatic test_full_table();
    longint v;
    int lo;
    int hi;
    no_idle = 1'b1;
    v = INT_MIN;
    for (int i = 0; i < DEPTH; i++) begin
      write_entry(i, v[DW-1:0]);
      if ($urandom_range(0, 3) != 0) v += $urandom_range(1, 4_000_000);
      if (v > INT_MAX) v = INT_MAX;
    end
    search_range(0, DEPTH - 1, table_copy[$urandom_range(0, DEPTH - 1)]);
    search_range(0, DEPTH - 1, INT_MAX);
    search_range(0, DEPTH - 1, table_copy[0] + 1);
    for (int i = 0; i < 60; i++) begin
      lo = $urandom_range(0, DEPTH - 1);
      hi = ($urandom_range(0, 19) == 0) ? $urandom_range(0, DEPTH - 1)
                                        : $urandom_range(lo, DEPTH - 1);
      search_range(lo, hi, pick_key(lo, hi));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_segments();
    longint v;
    int len;
    int step;
    int lo;
    int hi;
    logic signed [DW-1:0] key;
    logic dummy_hit;
    logic [IW-1:0] dummy_slot;
    wait_drain();
    while (item_count < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 12) begin
        // stray requests that break the sorted order or span arbitrary ranges
        if ($urandom_range(0, 1) == 0) begin
          write_entry($urandom_range(0, DEPTH - 1), $urandom);
        end else begin
          lo  = $urandom_range(0, DEPTH - 1);
          hi  = $urandom_range(0, DEPTH - 1);
          key = $urandom;
          if (!walk_table(lo, hi, key, dummy_hit, dummy_slot)) begin
            lo = seg_lo;
            hi = seg_hi;
          end
          search_range(lo, hi, key);
        end
      end else begin
        len    = ($urandom_range(0, 19) == 0) ? $urandom_range(49, 300) : $urandom_range(1, 48);
        seg_lo = $urandom_range(0, DEPTH - 1);
        if (seg_lo + len > DEPTH) len = DEPTH - seg_lo;
        seg_hi = seg_lo + len - 1;
        case ($urandom_range(0, 3))
          0: step = 1;
          1: step = 100;
          2: step = 65536;
          default: step = 1 << 24;
        endcase
        v = longint'(int'($urandom));
        for (int k = seg_lo; k <= seg_hi; k++) begin
          write_entry(k, v[DW-1:0]);
          v += $urandom_range(0, step);
          if (v > INT_MAX) v = INT_MAX;
        end
        repeat ($urandom_range(2, 8)) begin
          if ($urandom_range(0, 4) == 0) begin
            lo = seg_lo;
            hi = seg_hi;
          end else begin
            lo = $urandom_range(seg_lo, seg_hi);
            hi = $urandom_range(lo, seg_hi);
          end
          search_range(lo, hi, pick_key(lo, hi));
        end
        if ($urandom_range(0, 5) == 0) wait_drain();
      end
    end
  endtask

  // result checker and random output stalls
  initial begin
    search_result_t exp;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: found=%0b position=%0d", out_found, out_position);
        end else begin
          exp = expected_results.pop_front();
          if (out_found !== exp.found || out_position !== exp.position) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
                       exp.found, exp.position, out_found, out_position);
          end
        end
      end
      out_ready <= no_idle || ($urandom_range(0, 99) >= 9);
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
    $display("sorted_table_binary_search_core: mismatch");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= sbs_pkg::CMD_WRITE;
    in_entry_index <= '0;
    in_entry_value <= '0;
    in_low_index   <= '0;
    in_high_index  <= '0;
    in_search_key  <= '0;
    no_idle        = 1'b0;
    seg_lo         = 0;
    seg_hi         = 9;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_table();
    test_random_segments();

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatch_count++;
      $display("%0d search results never arrived", expected_results.size());
    end
    $display("covered %0d table writes and %0d searches (%0d hits, %0d misses)",
             write_count, search_count, hit_count, search_count - hit_count);
    $display("including full-table, empty, single-slot and unsorted ranges with random stalls");
    if (mismatch_count == 0) begin
      $display("sorted_table_binary_search_core: match");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("sorted_table_binary_search_core: mismatch");
    end
    $finish;
  end

endmodule
